[sv/lmlc_pkg.sv]
// Shared types and constants for the local Moran lag / cluster block.
// No dependencies; used by local_moran_lag_cluster.
`timescale 1ns / 1ps

package lmlc_pkg;

	// Neighbor list limits
	localparam int MAX_NEIGHBORS = 256;
	localparam int COUNT_CAP     = 511;
	localparam int CNT_LIMIT     = (MAX_NEIGHBORS < COUNT_CAP) ? MAX_NEIGHBORS : COUNT_CAP;

	// Field widths
	localparam int VAL_W  = 24;
	localparam int SUM_W  = 32;
	localparam int CNT_W  = 9;
	localparam int PROD_W = 48;
	localparam int CLS_W  = 3;
	localparam int QB_W   = $clog2(SUM_W);

	// Saturation limits
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] LAG_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] LAG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Cluster codes
	localparam logic [CLS_W-1:0] CL_HIGH_HIGH = 3'd0;
	localparam logic [CLS_W-1:0] CL_LOW_LOW   = 3'd1;
	localparam logic [CLS_W-1:0] CL_LOW_HIGH  = 3'd2;
	localparam logic [CLS_W-1:0] CL_HIGH_LOW  = 3'd3;
	localparam logic [CLS_W-1:0] CL_UNDEFINED = 3'd4;
	localparam logic [CLS_W-1:0] CL_ISOLATED  = 3'd5;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_MUL,
		ST_RESULT
	} state_t;

endpackage

[sv/local_moran_lag_cluster.sv]
// Local Moran's I with spatial lag and quadrant cluster, one observation per neighbor run.
// Depends on lmlc_pkg (types, limits, cluster codes).
`timescale 1ns / 1ps

// Each input transaction carries one neighbor entry of an observation; the run
// ends with tlast. A neighbor transaction is accepted, then accumulated. When
// neighbors were used, the closing transaction finds the lag by a 32-step
// restoring division (one quotient bit per cycle) on the one shared 33-bit adder,
// then a sign fix, then one 24x24 multiply. With no used neighbors the division
// and sign fix are skipped; an undefined observation or empty list goes straight
// to the result step. The result sits in an output register, so the next run is
// accepted while it waits; a closing transaction stalls in its last step only if
// the previous result has not yet been taken. Output transactions appear only for tlast.
module local_moran_lag_cluster (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: own_value[23:0], neighbor_value[47:24]
	input  logic [47:0] s_axis_tdata,
	// tuser: own_undefined[0], neighbor_undefined[1], neighbor_is_self[2], empty_list[3]
	input  logic [3:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: spatial_lag[23:0], local_moran[71:24], used_neighbors[80:72], zero[87:81]
	output logic [87:0] m_axis_tdata,
	// tuser: cluster[2:0]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready
);

	lmlc_pkg::state_t state_q, state_d;

	// Captured input transaction
	logic signed [lmlc_pkg::VAL_W-1:0]  own_q;
	logic                               own_undef_q;
	logic signed [lmlc_pkg::VAL_W-1:0]  nval_q;
	logic                               n_undef_q;
	logic                               n_self_q;
	logic                               empty_q;
	logic                               last_q;

	// Accumulators
	logic signed [lmlc_pkg::SUM_W-1:0]  sum_q;
	logic [lmlc_pkg::CNT_W-1:0]         cnt_q;

	// Divider registers
	logic [lmlc_pkg::SUM_W-1:0]         dvd_q;
	logic [lmlc_pkg::CNT_W-1:0]         rem_q;
	logic [lmlc_pkg::QB_W-1:0]          bit_cnt_q;
	logic                               neg_q;

	logic signed [lmlc_pkg::VAL_W-1:0]  lag_q;
	logic signed [lmlc_pkg::PROD_W-1:0] prod_q;

	// Output register
	logic                               out_valid_q;
	logic signed [lmlc_pkg::VAL_W-1:0]  out_lag_q;
	logic signed [lmlc_pkg::PROD_W-1:0] out_prod_q;
	logic [lmlc_pkg::CNT_W-1:0]         out_used_q;
	logic [lmlc_pkg::CLS_W-1:0]         out_cls_q;

	// Shared adder
	logic signed [lmlc_pkg::SUM_W:0]    alu_a, alu_b, alu_y;
	logic                               alu_sub;

	logic                               in_fire;
	logic                               add_en;
	logic                               out_free;
	logic                               special;
	logic [lmlc_pkg::CNT_W:0]           div_shift;
	logic                               q_bit;
	logic [lmlc_pkg::CLS_W-1:0]         cls_c;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign add_en   = !empty_q && !n_undef_q && !n_self_q &&
	                  (cnt_q < lmlc_pkg::CNT_W'(lmlc_pkg::CNT_LIMIT));
	assign out_free = !out_valid_q || m_axis_tready;
	assign special  = own_undef_q || empty_q;

	// Shared adder/subtractor
	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	// Division step: shift in next dividend bit, trial subtract
	assign div_shift = {rem_q, dvd_q[lmlc_pkg::SUM_W-1]};
	assign q_bit     = !alu_y[lmlc_pkg::SUM_W];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lmlc_pkg::ST_IDLE: begin
				if (in_fire)
					state_d = lmlc_pkg::ST_ACC;
			end
			lmlc_pkg::ST_ACC: begin
				if (!last_q)
					state_d = lmlc_pkg::ST_IDLE;
				else if (special)
					state_d = lmlc_pkg::ST_RESULT;
				else
					state_d = lmlc_pkg::ST_ABS;
			end
			lmlc_pkg::ST_ABS: begin
				if (cnt_q == '0)
					state_d = lmlc_pkg::ST_MUL;
				else
					state_d = lmlc_pkg::ST_DIV;
			end
			lmlc_pkg::ST_DIV: begin
				if (bit_cnt_q == lmlc_pkg::QB_W'(lmlc_pkg::SUM_W - 1))
					state_d = lmlc_pkg::ST_SIGN;
			end
			lmlc_pkg::ST_SIGN:   state_d = lmlc_pkg::ST_MUL;
			lmlc_pkg::ST_MUL:    state_d = lmlc_pkg::ST_RESULT;
			lmlc_pkg::ST_RESULT: begin
				if (out_free)
					state_d = lmlc_pkg::ST_IDLE;
			end
			default: state_d = lmlc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: adder operands and input ready
	always_comb begin
		alu_a         = '0;
		alu_b         = '0;
		alu_sub       = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			lmlc_pkg::ST_IDLE: s_axis_tready = 1'b1;
			lmlc_pkg::ST_ACC: begin
				alu_a = (lmlc_pkg::SUM_W+1)'(sum_q);
				alu_b = (lmlc_pkg::SUM_W+1)'(nval_q);
			end
			lmlc_pkg::ST_ABS: begin
				alu_b   = (lmlc_pkg::SUM_W+1)'(sum_q);
				alu_sub = 1'b1;
			end
			lmlc_pkg::ST_DIV: begin
				alu_a   = $signed((lmlc_pkg::SUM_W+1)'(div_shift));
				alu_b   = $signed((lmlc_pkg::SUM_W+1)'(cnt_q));
				alu_sub = 1'b1;
			end
			lmlc_pkg::ST_SIGN: begin
				if (neg_q)
					alu_b = $signed({1'b0, dvd_q});
				else
					alu_a = $signed({1'b0, dvd_q});
				alu_sub = neg_q;
			end
			default: ;
		endcase
	end

	// Quadrant class of a finished lag, or the undefined or isolated code
	always_comb begin
		if (own_undef_q)
			cls_c = lmlc_pkg::CL_UNDEFINED;
		else if (empty_q)
			cls_c = lmlc_pkg::CL_ISOLATED;
		else if (own_q > 0 && lag_q < 0)
			cls_c = lmlc_pkg::CL_HIGH_LOW;
		else if (own_q < 0 && lag_q > 0)
			cls_c = lmlc_pkg::CL_LOW_HIGH;
		else if (own_q < 0 && lag_q < 0)
			cls_c = lmlc_pkg::CL_LOW_LOW;
		else
			cls_c = lmlc_pkg::CL_HIGH_HIGH;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lmlc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			own_q       <= $signed(s_axis_tdata[23:0]);
			nval_q      <= $signed(s_axis_tdata[47:24]);
			own_undef_q <= s_axis_tuser[0];
			n_undef_q   <= s_axis_tuser[1];
			n_self_q    <= s_axis_tuser[2];
			empty_q     <= s_axis_tuser[3];
			last_q      <= s_axis_tlast;
		end
	end

	// Accumulators: saturating sum and capped count, cleared per run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (state_q == lmlc_pkg::ST_ACC && add_en) begin
			if (alu_y[lmlc_pkg::SUM_W] != alu_y[lmlc_pkg::SUM_W-1])
				sum_q <= alu_y[lmlc_pkg::SUM_W] ? lmlc_pkg::SUM_MIN : lmlc_pkg::SUM_MAX;
			else
				sum_q <= alu_y[lmlc_pkg::SUM_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == lmlc_pkg::ST_RESULT && out_free) begin
			sum_q <= '0;
			cnt_q <= '0;
		end
	end

	// Divide, sign fix and multiply datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lmlc_pkg::ST_ABS: begin
				dvd_q     <= sum_q[lmlc_pkg::SUM_W-1] ? alu_y[lmlc_pkg::SUM_W-1:0] : sum_q;
				neg_q     <= sum_q[lmlc_pkg::SUM_W-1];
				rem_q     <= '0;
				bit_cnt_q <= '0;
				lag_q     <= '0;
			end
			lmlc_pkg::ST_DIV: begin
				rem_q     <= q_bit ? alu_y[lmlc_pkg::CNT_W-1:0] : div_shift[lmlc_pkg::CNT_W-1:0];
				dvd_q     <= {dvd_q[lmlc_pkg::SUM_W-2:0], q_bit};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			lmlc_pkg::ST_SIGN: begin
				if (alu_y > (lmlc_pkg::SUM_W+1)'(lmlc_pkg::LAG_MAX))
					lag_q <= lmlc_pkg::LAG_MAX;
				else if (alu_y < (lmlc_pkg::SUM_W+1)'(lmlc_pkg::LAG_MIN))
					lag_q <= lmlc_pkg::LAG_MIN;
				else
					lag_q <= alu_y[lmlc_pkg::VAL_W-1:0];
			end
			lmlc_pkg::ST_MUL: prod_q <= own_q * lag_q;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == lmlc_pkg::ST_RESULT && out_free)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == lmlc_pkg::ST_RESULT && out_free) begin
			out_cls_q <= cls_c;
			if (special) begin
				out_lag_q  <= '0;
				out_prod_q <= '0;
				out_used_q <= '0;
			end else begin
				out_lag_q  <= lag_q;
				out_prod_q <= prod_q;
				out_used_q <= cnt_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_used_q, out_prod_q, out_lag_q};
	assign m_axis_tuser  = out_cls_q;

	// Checks
	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lmlc_pkg::ST_RESULT))
		else $error("output valid raised outside result step");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lmlc_pkg::CNT_W'(lmlc_pkg::CNT_LIMIT))
		else $error("neighbor count beyond limit");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmlc_pkg::ST_DIV |-> rem_q < cnt_q)
		else $error("division remainder not below divisor");

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_cls_q == lmlc_pkg::CL_UNDEFINED ||
		                out_cls_q == lmlc_pkg::CL_ISOLATED)
		|-> out_lag_q == '0 && out_prod_q == '0 && out_used_q == '0)
		else $error("special class with nonzero payload");

	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == lmlc_pkg::ST_ACC)
		else $error("accepted transaction not accumulated");

endmodule

[dv/testbench.sv]
// Self-checking testbench for local_moran_lag_cluster: neighbor runs in, LISA results out.
// Depends on lmlc_pkg and local_moran_lag_cluster; a built-in predictor computes lag, product,
// used count and cluster class per observation.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_ITEMS   = 1950;

	// One neighbor entry as it travels on the input stream
	typedef struct {
		logic signed [lmlc_pkg::VAL_W-1:0] own_value;
		logic                              own_undef;
		logic signed [lmlc_pkg::VAL_W-1:0] nbr_value;
		logic                              nbr_undef;
		logic                              nbr_self;
		logic                              empty_list;
		logic                              is_last;
		bit                                drain_first;
	} nbr_item_t;

	// One observation result
	typedef struct {
		logic [lmlc_pkg::VAL_W-1:0]  lag;
		logic [lmlc_pkg::PROD_W-1:0] moran;
		logic [lmlc_pkg::CNT_W-1:0]  used;
		logic [lmlc_pkg::CLS_W-1:0]  cls;
	} lisa_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic [47:0] s_axis_tdata  = '0;
	logic [3:0]  s_axis_tuser  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;

	nbr_item_t    nbr_pending_q[$];
	lisa_result_t lisa_expect_q[$];
	nbr_item_t    nbr_in_flight;

	// Predictor state
	longint acc_sum   = 0;
	int     acc_count = 0;

	int total_items   = 0;
	int sent_items    = 0;
	int accepted_nbrs = 0;
	int checked_obs   = 0;
	int undef_obs     = 0;
	int isolated_obs  = 0;
	int capped_obs    = 0;
	int error_count   = 0;
	int stall_cycles  = 0;
	int long_lists    = 0;

	always #1 clk = ~clk;

	local_moran_lag_cluster i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	// Idle percentages per phase: sender light / receiver heavy, swapped, then none
	function automatic int phase_of_run();
		if (sent_items < total_items / 3) return 0;
		if (sent_items < (2 * total_items) / 3) return 1;
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (phase_of_run())
			0:       return 19;
			1:       return 64;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (phase_of_run())
			0:       return 64;
			1:       return 19;
			default: return 0;
		endcase
	endfunction

	// Fold one neighbor transaction into the running sum; on tlast produce the observation result
	function automatic bit lisa_accumulate(input nbr_item_t it, output lisa_result_t res);
		longint own;
		longint lag;
		longint prod;
		own  = it.own_value;
		lag  = 0;
		prod = 0;
		res  = '{default: '0};
		if (!it.empty_list && !it.nbr_undef && !it.nbr_self &&
				acc_count < lmlc_pkg::CNT_LIMIT) begin
			acc_sum = acc_sum + longint'(it.nbr_value);
			if (acc_sum > longint'(lmlc_pkg::SUM_MAX)) acc_sum = longint'(lmlc_pkg::SUM_MAX);
			if (acc_sum < longint'(lmlc_pkg::SUM_MIN)) acc_sum = longint'(lmlc_pkg::SUM_MIN);
			acc_count++;
		end
		if (!it.is_last)
			return 1'b0;

		if (it.own_undef) begin
			res.cls = lmlc_pkg::CL_UNDEFINED;
			undef_obs++;
		end else if (it.empty_list) begin
			res.cls = lmlc_pkg::CL_ISOLATED;
			isolated_obs++;
		end else begin
			// truncating division; no used neighbors leaves the lag at zero
			if (acc_count != 0)
				lag = acc_sum / longint'(acc_count);
			if (lag > longint'(lmlc_pkg::LAG_MAX)) lag = longint'(lmlc_pkg::LAG_MAX);
			if (lag < longint'(lmlc_pkg::LAG_MIN)) lag = longint'(lmlc_pkg::LAG_MIN);
			prod = own * lag;
			if (own > 0 && lag < 0)
				res.cls = lmlc_pkg::CL_HIGH_LOW;
			else if (own < 0 && lag > 0)
				res.cls = lmlc_pkg::CL_LOW_HIGH;
			else if (own < 0 && lag < 0)
				res.cls = lmlc_pkg::CL_LOW_LOW;
			else
				res.cls = lmlc_pkg::CL_HIGH_HIGH;
			res.lag   = lag[lmlc_pkg::VAL_W-1:0];
			res.moran = prod[lmlc_pkg::PROD_W-1:0];
			res.used  = acc_count[lmlc_pkg::CNT_W-1:0];
			if (acc_count == lmlc_pkg::CNT_LIMIT) capped_obs++;
		end
		acc_sum   = 0;
		acc_count = 0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	// Driver: presents queued neighbor transactions, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		nbr_item_t    nxt;
		lisa_result_t res;
		bit           accepted;
		bit           hold;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			accepted = s_axis_tvalid && s_axis_tready;
			if (accepted) begin
				accepted_nbrs++;
				if (lisa_accumulate(nbr_in_flight, res))
					lisa_expect_q.insert(lisa_expect_q.size(), res);
			end
			if (!s_axis_tvalid || accepted) begin
				hold = (nbr_pending_q.size() == 0) ||
					($urandom_range(0, 99) < sender_idle_pct()) ||
					(nbr_pending_q[0].drain_first && lisa_expect_q.size() != 0);
				if (hold) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					nxt = nbr_pending_q.pop_front();
					nbr_in_flight = nxt;
					sent_items++;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {nxt.nbr_value, nxt.own_value};
					s_axis_tuser  <= {nxt.empty_list, nxt.nbr_self, nxt.nbr_undef, nxt.own_undef};
					s_axis_tlast  <= nxt.is_last;
				end
			end
		end
	end

	// Monitor: takes results under random backpressure and checks them in order
	always @(posedge clk or negedge arst_n) begin
		lisa_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (lisa_expect_q.size() == 0) begin
					report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata[60:0]}, '0);
				end else begin
					want = lisa_expect_q.pop_front();
					checked_obs++;
					check_field("spatial_lag", m_axis_tdata[23:0], want.lag);
					check_field("local_moran", m_axis_tdata[71:24], want.moran);
					check_field("used_neighbors", m_axis_tdata[80:72], want.used);
					check_field("padding", m_axis_tdata[87:81], '0);
					check_field("cluster", m_axis_tuser, want.cls);
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// Watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_nbr(input logic signed [lmlc_pkg::VAL_W-1:0] own, input logic own_undef,
			input logic signed [lmlc_pkg::VAL_W-1:0] nval, input logic nbr_undef,
			input logic nbr_self, input logic empty, input logic is_last, input bit drain);
		nbr_item_t it;
		it.own_value   = own;
		it.own_undef   = own_undef;
		it.nbr_value   = nval;
		it.nbr_undef   = nbr_undef;
		it.nbr_self    = nbr_self;
		it.empty_list  = empty;
		it.is_last     = is_last;
		it.drain_first = drain;
		nbr_pending_q.insert(nbr_pending_q.size(), it);
	endtask

	// Q8.16 values biased toward zero, the extremes and small magnitudes
	function automatic logic signed [lmlc_pkg::VAL_W-1:0] rand_q816();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return lmlc_pkg::LAG_MAX;
			2:       return lmlc_pkg::LAG_MIN;
			3:       return $signed({7'b0, r[16:0]});
			4:       return -$signed({7'b0, r[16:0]});
			default: return r[lmlc_pkg::VAL_W-1:0];
		endcase
	endfunction

	// One observation: a well-formed neighbor run with random content and occasional noise
	task automatic add_observation(input int len, input bit drain);
		logic signed [lmlc_pkg::VAL_W-1:0] own;
		logic                              own_undef;
		bit                                lst;
		own       = rand_q816();
		own_undef = ($urandom_range(0, 15) == 0);
		if ($urandom_range(0, 15) == 0) begin
			// isolated observation, sometimes with undefined value
			add_nbr(own, own_undef, rand_q816(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b1, 1'b1, drain);
			return;
		end
		for (int i = 0; i < len; i++) begin
			lst = (i == len - 1);
			add_nbr((!lst && $urandom_range(0, 9) == 0) ? rand_q816() : own,
				lst ? own_undef : 1'($urandom_range(0, 1)),
				rand_q816(),
				$urandom_range(0, 7) == 0,
				$urandom_range(0, 9) == 0,
				$urandom_range(0, 31) == 0,
				lst, drain && i == 0);
		end
	endtask

	initial begin
		int len;
		// Directed: precedence, isolation, every quadrant, no used neighbors, truncation
		add_nbr(lmlc_pkg::LAG_MAX, 1'b1, lmlc_pkg::LAG_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		add_nbr(24'sd1000, 1'b0, 24'sd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		add_nbr(lmlc_pkg::LAG_MAX, 1'b0, lmlc_pkg::LAG_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(lmlc_pkg::LAG_MAX, 1'b0, lmlc_pkg::LAG_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		add_nbr(lmlc_pkg::LAG_MIN, 1'b0, lmlc_pkg::LAG_MIN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(lmlc_pkg::LAG_MIN, 1'b0, lmlc_pkg::LAG_MIN, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		add_nbr(lmlc_pkg::LAG_MIN, 1'b0, lmlc_pkg::LAG_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(lmlc_pkg::LAG_MIN, 1'b0, 24'sd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		add_nbr(lmlc_pkg::LAG_MAX, 1'b0, lmlc_pkg::LAG_MIN, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		// only undefined and self entries: lag zero
		add_nbr(-24'sd5, 1'b0, lmlc_pkg::LAG_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(-24'sd5, 1'b0, lmlc_pkg::LAG_MIN, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
		// empty flag on an earlier entry contributes nothing
		add_nbr(24'sd77, 1'b0, 24'sd100, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
		add_nbr(24'sd77, 1'b0, -24'sd300, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		// empty on the closing entry overrides what was accumulated
		add_nbr(24'sd9, 1'b0, 24'sd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(24'sd9, 1'b0, 24'sd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		// undefined beats empty
		add_nbr(-24'sd9, 1'b1, 24'sd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		// own zero with negative lag stays high-high
		add_nbr(24'sd0, 1'b0, -24'sd7, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		// -1/3 truncates toward zero
		add_nbr(24'sd3, 1'b0, -24'sd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(24'sd3, 1'b0, -24'sd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_nbr(24'sd3, 1'b0, 24'sd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);

		// Random runs: mostly short lists, a few long enough to hit the neighbor cap
		add_observation(3, 1'b1);
		while (nbr_pending_q.size() < RANDOM_ITEMS) begin
			if ((nbr_pending_q.size() > 600 && long_lists == 0) ||
					(nbr_pending_q.size() > 1400 && long_lists == 1)) begin
				len = $urandom_range(lmlc_pkg::CNT_LIMIT + lmlc_pkg::CNT_LIMIT / 2,
					lmlc_pkg::CNT_LIMIT + lmlc_pkg::CNT_LIMIT / 2 + 40);
				long_lists++;
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(9, 24);
			end else begin
				len = $urandom_range(1, 8);
			end
			add_observation(len, long_lists == 1 && nbr_pending_q.size() > 1000 &&
				nbr_pending_q.size() < 1020);
		end
		total_items = nbr_pending_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (nbr_pending_q.size() != 0 || s_axis_tvalid || lisa_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d neighbor transactions, checked %0d observation results",
			accepted_nbrs, checked_obs);
		$display("Covered %0d undefined, %0d isolated and %0d capped observations",
			undef_obs, isolated_obs, capped_obs);
		if (error_count == 0 && lisa_expect_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
sv/lmlc_pkg.sv
sv/local_moran_lag_cluster.sv
dv/testbench.sv
